FILE: hw/rtl/assert_macros.svh
// Assertion macros for the RTL files of the cache hit/miss unit; the controller includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge except while reset is held.
`define AST_CLK(lbl, pr) \
  lbl: assert property (@(posedge clk) disable iff (rst) pr) \
    else $error("assertion failed");

// Checked on every clock edge, reset included.
`define AST_ALL(lbl, pr) \
  lbl: assert property (@(posedge clk) pr) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/sac_pkg.sv
// Package with the types and constants of the cache hit/miss unit.
package sac_pkg;

  localparam int MAX_SETS      = 64;
  localparam int MAX_WAYS      = 8;
  localparam int AGE_BITS      = 16;
  localparam int SET_W         = $clog2(MAX_SETS);
  localparam int WAY_W         = 3;
  localparam int WAYS_W        = 4;
  localparam int TAG_W         = 30;
  localparam int AGE_MAX       = (1 << AGE_BITS) - 1;

  localparam logic [1:0] POL_FIFO = 2'd0;
  localparam logic [1:0] POL_MRU  = 2'd1;
  localparam logic [1:0] POL_LRU  = 2'd2;

  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_SETS   = 2'd1;
  localparam logic [1:0] REG_WAYS   = 2'd2;
  localparam logic [1:0] REG_WORDS  = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  typedef struct packed {
    logic [1:0] policy;
    logic [2:0] sets_log2;
    logic [3:0] ways_in_use;
    logic [2:0] words_log2;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

  typedef struct packed {
    logic [MAX_WAYS-1:0][TAG_W-1:0]    tags;
    logic [MAX_WAYS-1:0]               valid;
    logic [MAX_WAYS-1:0][AGE_BITS-1:0] ages;
    logic [WAY_W-1:0]                  fifo;
    logic [WAY_W-1:0]                  mru;
  } row_t;

  localparam int ROW_W = $bits(row_t);

endpackage

FILE: hw/rtl/set_assoc_cache_hit_miss_unit.sv
// An accepted item is first read from the set's row RAM through its registered port,
// then committed: all ways are compared, the victim is picked, the row is written back
// and the result goes to the output registers. A new item is taken only after the commit.
// A result waiting at the output stalls only the commit of the following item.
// Reset clears the row-valid bits, the counters, the sequencer and the registers to
// FIFO, one set, one way, one word per block; there is no clearing pass.
module set_assoc_cache_hit_miss_unit import sac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hit,
  output logic [2:0]  way_used,
  output logic [31:0] hit_count,
  output logic [31:0] miss_count
);

  // Configuration registers. Software must change them only while the unit is idle;
  // the unit itself does not enforce this, and the datapath reads them directly.
  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.policy      <= POL_FIFO;
      cfg.sets_log2   <= '0;
      cfg.ways_in_use <= 4'd1;
      cfg.words_log2  <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_POLICY: cfg.policy      <= pwdata[1:0];
        REG_SETS:   cfg.sets_log2   <= pwdata[2:0];
        REG_WAYS:   cfg.ways_in_use <= pwdata[3:0];
        REG_WORDS:  cfg.words_log2  <= pwdata[2:0];
        default:    cfg.policy      <= cfg.policy;
      endcase
    end
  end

  // Read-back returns the register selected by the word address, zero extended.
  always_comb begin
    case (paddr[3:2])
      REG_POLICY: prdata = 32'(cfg.policy);
      REG_SETS:   prdata = 32'(cfg.sets_log2);
      REG_WAYS:   prdata = 32'(cfg.ways_in_use);
      REG_WORDS:  prdata = 32'(cfg.words_log2);
      default:    prdata = '0;
    endcase
  end

  // The sequencer issues the row read when an item is taken and the commit
  // once the output register is free to take the result.
  sac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sac_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts),
    .address    (address),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hit        (hit),
    .way_used   (way_used),
    .hit_count  (hit_count),
    .miss_count (miss_count)
  );

endmodule

FILE: hw/rtl/sac_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module sac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/sac_dpath.sv
// Datapath: set row lookup, tag compare, victim choice, row write-back and counters.
module sac_dpath import sac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [31:0] address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hit,
  output logic [2:0]  way_used,
  output logic [31:0] hit_count,
  output logic [31:0] miss_count
);

  logic [TAG_W-1:0]    blk_q;
  logic [SET_W-1:0]    set_q;
  logic [TAG_W-1:0]    blk_in;
  logic [SET_W-1:0]    set_in;
  logic [2:0]          sl;
  logic [SET_W-1:0]    set_mask;
  logic [MAX_SETS-1:0] row_init;
  logic [ROW_W-1:0]    rdata;
  row_t                row;
  row_t                row_new;
  logic [WAYS_W-1:0]   ways;
  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0][AGE_BITS-1:0] aged;
  logic                is_hit;
  logic [WAY_W-1:0]    hit_way;
  logic                any_free;
  logic [WAY_W-1:0]    free_way;
  logic [WAY_W-1:0]    mru_v;
  logic [WAY_W-1:0]    fifo_v;
  logic [WAYS_W-1:0]   fifo_inc;
  logic [WAY_W-1:0]    fifo_adv;
  logic [WAY_W-1:0]    lru_v;
  logic [AGE_BITS-1:0] best;
  logic [WAY_W-1:0]    way;
  logic                use_fifo;
  logic [31:0]         hits_total;
  logic [31:0]         misses_total;

  assign sl       = (cfg.sets_log2 > 3'(SET_W)) ? 3'(SET_W) : cfg.sets_log2;
  assign set_mask = SET_W'((7'(1) << sl) - 7'(1));
  assign blk_in   = TAG_W'(address >> (6'(2) + 6'(cfg.words_log2)));
  assign set_in   = blk_in[SET_W-1:0] & set_mask;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      blk_q <= blk_in;
      set_q <= set_in;
    end
  end

  sac_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SETS)) u_row_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (set_q),
    .wdata (row_new),
    .re    (cmd.capture),
    .raddr (set_in),
    .rdata (rdata)
  );

  assign row = row_init[set_q] ? row_t'(rdata) : '0;

  always_comb begin
    if (cfg.ways_in_use == '0) begin
      ways = 4'd1;
    end else if (cfg.ways_in_use > 4'(MAX_WAYS)) begin
      ways = 4'(MAX_WAYS);
    end else begin
      ways = cfg.ways_in_use;
    end
  end

  always_comb begin
    is_hit   = 1'b0;
    hit_way  = '0;
    any_free = 1'b0;
    free_way = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      in_use[i] = (4'(i) < ways);
      aged[i]   = (in_use[i] && row.ages[i] != AGE_BITS'(AGE_MAX)) ?
                  row.ages[i] + AGE_BITS'(1) : row.ages[i];
    end
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (in_use[i] && row.valid[i] && row.tags[i] == blk_q) begin
        is_hit  = 1'b1;
        hit_way = WAY_W'(i);
      end
      if (in_use[i] && !row.valid[i]) begin
        any_free = 1'b1;
        free_way = WAY_W'(i);
      end
    end
  end

  always_comb begin
    best  = aged[0];
    lru_v = '0;
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (in_use[i] && aged[i] > best) begin
        best  = aged[i];
        lru_v = WAY_W'(i);
      end
    end
  end

  assign mru_v    = (4'(row.mru) < ways) ? row.mru : '0;
  assign fifo_v   = (4'(row.fifo) < ways) ? row.fifo : '0;
  assign fifo_inc = 4'(fifo_v) + 4'd1;
  assign fifo_adv = (fifo_inc < ways) ? fifo_inc[WAY_W-1:0] : '0;
  assign use_fifo = !is_hit && !any_free &&
                    (cfg.policy != POL_MRU) && (cfg.policy != POL_LRU);

  always_comb begin
    if (is_hit) begin
      way = hit_way;
    end else if (any_free) begin
      way = free_way;
    end else begin
      case (cfg.policy)
        POL_MRU: way = mru_v;
        POL_LRU: way = lru_v;
        default: way = fifo_v;
      endcase
    end
  end

  always_comb begin
    row_new      = row;
    row_new.ages = aged;
    row_new.ages[way] = '0;
    row_new.mru  = way;
    if (!is_hit) begin
      row_new.tags[way]  = blk_q;
      row_new.valid[way] = 1'b1;
    end
    if (use_fifo) begin
      row_new.fifo = fifo_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_init     <= '0;
      hits_total   <= '0;
      misses_total <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.commit) begin
        row_init[set_q] <= 1'b1;
        if (is_hit && hits_total != '1) begin
          hits_total <= hits_total + 32'd1;
        end
        if (!is_hit && misses_total != '1) begin
          misses_total <= misses_total + 32'd1;
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit      <= is_hit;
      way_used <= way;
    end
  end

  assign hit_count    = hits_total;
  assign miss_count   = misses_total;
  assign sts.out_busy = out_valid && !out_ready;

endmodule

FILE: hw/rtl/sac_ctrl.sv
// Controller: two-state sequencer that accepts an item and commits its lookup.
`include "assert_macros.svh"

module sac_ctrl import sac_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.commit = !sts.out_busy;
        if (!sts.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `AST_ALL(a_reset_idle, rst |=> state == ST_IDLE)
  `AST_CLK(a_no_overlap, !(in_ready && cmd.commit))
  `AST_CLK(a_commit_free, cmd.commit |-> !sts.out_busy)
  `AST_CLK(a_accept_lookup, (in_valid && in_ready) |=> state == ST_LOOKUP)

endmodule
